FILE: rtl/csps_pkg.sv
// Shared types, standard codes and the through-level map for the
// calibration standard port switch. No dependencies.
package csps_pkg;

  localparam int NUM_PORTS = 4;
  localparam int PORT_W    = 2;
  localparam int STD_W     = 3;
  localparam int LEVEL_W   = 3;

  typedef logic [PORT_W-1:0]  port_idx_t;
  typedef logic [STD_W-1:0]   std_code_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef std_code_t [NUM_PORTS-1:0] std_vec_t;
  typedef port_idx_t [NUM_PORTS-1:0] part_vec_t;
  typedef level_t    [NUM_PORTS-1:0] level_vec_t;

  localparam std_code_t STD_NONE    = 3'd0;
  localparam std_code_t STD_OPEN    = 3'd1;
  localparam std_code_t STD_SHORT   = 3'd2;
  localparam std_code_t STD_LOAD    = 3'd3;
  localparam std_code_t STD_THROUGH = 3'd4;

  localparam logic FUNC_SET_STD  = 1'b0;
  localparam logic FUNC_SET_THRU = 1'b1;

  // Fixed levels, packed V0 | V1<<1 | V2<<2
  localparam level_t LVL_NONE  = 3'd3;
  localparam level_t LVL_OPEN  = 3'd0;
  localparam level_t LVL_SHORT = 3'd1;
  localparam level_t LVL_LOAD  = 3'd5;

  // Through levels indexed [port][partner]
  localparam level_t THRU_LEVELS [NUM_PORTS][NUM_PORTS] = '{
    '{3'd3, 3'd2, 3'd6, 3'd4},
    '{3'd6, 3'd3, 3'd2, 3'd4},
    '{3'd4, 3'd2, 3'd3, 3'd6},
    '{3'd4, 3'd6, 3'd2, 3'd3}
  };

endpackage

FILE: rtl/csps_levels.sv
// Switch-pin level decoder: maps each port's standard and partner to its
// three control levels. Depends on csps_pkg.
module csps_levels
  import csps_pkg::*;
(
  input  std_vec_t   stds,
  input  part_vec_t  parts,
  output level_vec_t levels
);

  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      case (stds[i])
        STD_OPEN:    levels[i] = LVL_OPEN;
        STD_SHORT:   levels[i] = LVL_SHORT;
        STD_LOAD:    levels[i] = LVL_LOAD;
        STD_THROUGH: levels[i] = THRU_LEVELS[i][parts[i]];
        default:     levels[i] = LVL_NONE;
      endcase
    end
  end

endmodule

FILE: rtl/cal_standard_port_switch_top.sv
// Top level of the calibration standard port switch: command register,
// port state update and result register. Depends on csps_pkg, csps_levels.

// One command is taken per clock cycle; busy is always low. A transferred
// command is captured in the command register; its result passes through
// the state update into the result register, and out_valid flags it for
// exactly one cycle. The receiver cannot stall, so results must be taken
// when out_valid is high. Refused commands still produce a result, with
// out_accepted low and the current state.
module cal_standard_port_switch_top
  import csps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_func,
  input  logic [2:0]               in_port,
  input  logic [2:0]               in_value,
  output logic                     out_valid,
  output logic [11:0]              out_pins,
  output logic                     out_accepted,
  output logic [11:0]              out_standards,
  output logic [7:0]               out_partners
);

  logic       cmd_valid_r;
  logic       func_r;
  logic [2:0] port_r;
  logic [2:0] value_r;

  std_vec_t   std_r,  std_nxt;
  part_vec_t  part_r, part_nxt;
  logic       ok_nxt;
  level_vec_t levels;

  logic       out_valid_r;
  logic [11:0] pins_r;
  logic        ok_r;
  logic [11:0] stds_out_r;
  logic [7:0]  parts_out_r;

  port_idx_t  p_idx;
  port_idx_t  d_idx;
  port_idx_t  q_idx;

  assign busy = 1'b0;

  // Command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r  <= in_func;
      port_r  <= in_port;
      value_r <= in_value;
    end
  end

  assign p_idx = port_r[PORT_W-1:0];
  assign d_idx = value_r[PORT_W-1:0];

  // State update; a release drops the old through partner back to none
  always_comb begin
    std_nxt  = std_r;
    part_nxt = part_r;
    ok_nxt   = 1'b0;
    q_idx    = '0;
    if (cmd_valid_r) begin
      if (func_r == FUNC_SET_STD) begin
        if (!port_r[2] && value_r < STD_THROUGH) begin
          if (std_nxt[p_idx] == STD_THROUGH) begin
            q_idx           = part_nxt[p_idx];
            std_nxt[q_idx]  = STD_NONE;
            part_nxt[q_idx] = '0;
            part_nxt[p_idx] = '0;
          end
          std_nxt[p_idx] = value_r;
          ok_nxt         = 1'b1;
        end
      end else begin
        if (port_r != value_r && !port_r[2] && !value_r[2]) begin
          if (std_nxt[p_idx] == STD_THROUGH) begin
            q_idx           = part_nxt[p_idx];
            std_nxt[q_idx]  = STD_NONE;
            part_nxt[q_idx] = '0;
            part_nxt[p_idx] = '0;
          end
          // second release sees the result of the first
          if (std_nxt[d_idx] == STD_THROUGH) begin
            q_idx           = part_nxt[d_idx];
            std_nxt[q_idx]  = STD_NONE;
            part_nxt[q_idx] = '0;
            part_nxt[d_idx] = '0;
          end
          std_nxt[p_idx]  = STD_THROUGH;
          std_nxt[d_idx]  = STD_THROUGH;
          part_nxt[p_idx] = d_idx;
          part_nxt[d_idx] = p_idx;
          ok_nxt          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_r  <= '0;
      part_r <= '0;
    end else begin
      std_r  <= std_nxt;
      part_r <= part_nxt;
    end
  end

  csps_levels u_levels (
    .stds   (std_nxt),
    .parts  (part_nxt),
    .levels (levels)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid_r) begin
      pins_r      <= levels;
      ok_r        <= ok_nxt;
      stds_out_r  <= std_nxt;
      parts_out_r <= part_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pins      = pins_r;
  assign out_accepted  = ok_r;
  assign out_standards = stds_out_r;
  assign out_partners  = parts_out_r;

  // Every transfer in gives exactly one result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("result strobe missing after command");

  // A refused command must leave the port state untouched
  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid_r && !ok_nxt) |=> (std_r == $past(std_r) && part_r == $past(part_r)))
    else $error("refused command changed port state");

  // Idle cycles never change state
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_valid_r |=> (std_r == $past(std_r) && part_r == $past(part_r)))
    else $error("port state changed without a command");

  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_pair_chk
    // Through pairs are symmetric and never self-paired
    a_pair_sym: assert property (@(posedge clk) disable iff (!rst_n)
      std_r[g] == STD_THROUGH |->
        (std_r[part_r[g]] == STD_THROUGH && part_r[part_r[g]] == port_idx_t'(g)
         && part_r[g] != port_idx_t'(g)))
      else $error("through pairing inconsistent");

    // A port that is not through carries partner zero
    a_part_clear: assert property (@(posedge clk) disable iff (!rst_n)
      std_r[g] != STD_THROUGH |-> part_r[g] == '0)
      else $error("stale partner on non-through port");
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for cal_standard_port_switch_top: random and directed
// port commands, results predicted in step. Depends on csps_pkg and that top.
`timescale 1ns / 100ps

module testbench;
  import csps_pkg::*;

  localparam int RANDOM_CMDS  = 1050;
  localparam int DRAIN_EVERY  = 300;
  localparam int TAIL_CYCLES  = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [2:0] BAD_CODE = 3'd7;

  typedef struct packed {
    logic       func;
    logic [2:0] port;
    logic [2:0] value;
    logic       drain;
  } command_t;

  typedef struct packed {
    logic [11:0] pins;
    logic        accepted;
    std_vec_t    standards;
    part_vec_t   partners;
  } switch_result_t;

  // Through levels, V0 | V1<<1 | V2<<2, indexed by port then partner
  localparam logic [2:0] THRU_PIN_MAP [4][4] = '{
    '{3'd3, 3'd2, 3'd6, 3'd4},
    '{3'd6, 3'd3, 3'd2, 3'd4},
    '{3'd4, 3'd2, 3'd3, 3'd6},
    '{3'd4, 3'd6, 3'd2, 3'd3}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [2:0]  in_port;
  logic [2:0]  in_value;
  logic        out_valid;
  logic [11:0] out_pins;
  logic        out_accepted;
  logic [11:0] out_standards;
  logic [7:0]  out_partners;

  command_t       pending_cmds[$];
  switch_result_t expected_states[$];
  std_vec_t       sw_std;
  part_vec_t      sw_partner;
  int             error_count;
  int             cycle_count;
  int             gap_left;
  int             burst_left;
  logic           draining;

  cal_standard_port_switch_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_port       (in_port),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_pins      (out_pins),
    .out_accepted  (out_accepted),
    .out_standards (out_standards),
    .out_partners  (out_partners)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Drop a through pairing: the partner falls back to none
  function automatic void release_port(port_idx_t p);
    port_idx_t q;
    if (sw_std[p] == STD_THROUGH) begin
      q = sw_partner[p];
      sw_std[q] = STD_NONE;
      sw_partner[q] = '0;
      sw_partner[p] = '0;
    end
  endfunction

  function automatic logic [2:0] pin_levels(int p);
    case (sw_std[p])
      STD_OPEN:    return 3'd0;
      STD_SHORT:   return 3'd1;
      STD_LOAD:    return 3'd5;
      STD_THROUGH: return THRU_PIN_MAP[p][sw_partner[p]];
      default:     return 3'd3;
    endcase
  endfunction

  function automatic switch_result_t apply_command(logic func, logic [2:0] port,
                                                   logic [2:0] value);
    switch_result_t res;
    res = '0;
    if (func == FUNC_SET_STD) begin
      if (port < NUM_PORTS && value < STD_THROUGH) begin
        release_port(port[1:0]);
        sw_std[port[1:0]] = value;
        res.accepted = 1'b1;
      end
    end else if (port != value && port < NUM_PORTS && value < NUM_PORTS) begin
      release_port(port[1:0]);
      release_port(value[1:0]);
      sw_std[port[1:0]]      = STD_THROUGH;
      sw_std[value[1:0]]     = STD_THROUGH;
      sw_partner[port[1:0]]  = value[1:0];
      sw_partner[value[1:0]] = port[1:0];
      res.accepted = 1'b1;
    end
    for (int i = 0; i < NUM_PORTS; i++) res.pins[3*i +: 3] = pin_levels(i);
    res.standards = sw_std;
    res.partners  = sw_partner;
    return res;
  endfunction

  // Mostly back-to-back or short gaps, a few long ones, and bursts with none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_cmd(logic func, logic [2:0] port, logic [2:0] value);
    command_t c;
    c.func  = func;
    c.port  = port;
    c.value = value;
    c.drain = 1'b0;
    pending_cmds.push_back(c);
  endtask

  task automatic add_drain();
    command_t c;
    c = '0;
    c.drain = 1'b1;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Driver: record each transfer, then present the next command after its gap
  always @(posedge clk) begin : driver
    command_t cmd;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_states.push_back(apply_command(in_func, in_port, in_value));
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        start    <= 1'b0;
        in_func  <= 1'($urandom_range(0, 1));
        in_port  <= 3'($urandom_range(0, 7));
        in_value <= 3'($urandom_range(0, 7));
      end else if (draining) begin
        if (expected_states.size() == 0) draining = 1'b0;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd = pending_cmds.pop_front();
        if (cmd.drain) begin
          draining = 1'b1;
          start <= 1'b0;
        end else begin
          start    <= 1'b1;
          in_func  <= cmd.func;
          in_port  <= cmd.port;
          in_value <= cmd.value;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    switch_result_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pins 0x%0h", $time,
                 out_pins);
        error_count++;
      end else begin
        exp_res = expected_states.pop_front();
        check_field("pins", 32'(exp_res.pins), 32'(out_pins));
        check_field("accepted", 32'(exp_res.accepted), 32'(out_accepted));
        check_field("standards", 32'(exp_res.standards), 32'(out_standards));
        check_field("partners", 32'(exp_res.partners), 32'(out_partners));
      end
    end
  end

  initial begin : timeout
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int r;
    logic       func;
    logic [2:0] port;
    logic [2:0] value;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = 1'b0;
    in_port     = '0;
    in_value    = '0;
    sw_std      = '0;
    sw_partner  = '0;
    error_count = 0;
    cycle_count = 0;
    gap_left    = 0;
    burst_left  = 0;
    draining    = 1'b0;

    // Directed: every standard, every refusal, pairing and re-pairing
    add_cmd(FUNC_SET_STD, 3'd7, STD_NONE);
    add_cmd(FUNC_SET_STD, 3'd0, STD_OPEN);
    add_cmd(FUNC_SET_STD, 3'd1, STD_SHORT);
    add_cmd(FUNC_SET_STD, 3'd2, STD_LOAD);
    add_cmd(FUNC_SET_STD, 3'd3, STD_NONE);
    add_cmd(FUNC_SET_STD, 3'd0, STD_THROUGH);
    add_cmd(FUNC_SET_STD, 3'd1, BAD_CODE);
    add_cmd(FUNC_SET_STD, 3'd4, STD_OPEN);
    add_cmd(FUNC_SET_THRU, 3'd0, 3'd1);
    add_cmd(FUNC_SET_THRU, 3'd2, 3'd3);
    add_cmd(FUNC_SET_THRU, 3'd1, 3'd2);
    add_cmd(FUNC_SET_STD, 3'd1, STD_LOAD);
    add_cmd(FUNC_SET_THRU, 3'd3, 3'd3);
    add_cmd(FUNC_SET_THRU, 3'd3, 3'd7);
    add_cmd(FUNC_SET_THRU, 3'd6, 3'd0);
    add_cmd(FUNC_SET_THRU, 3'd3, 3'd0);
    add_cmd(FUNC_SET_THRU, 3'd0, 3'd3);
    add_cmd(FUNC_SET_THRU, 3'd1, 3'd0);
    add_cmd(FUNC_SET_STD, 3'd5, 3'd5);
    add_cmd(FUNC_SET_THRU, 3'd7, 3'd7);
    add_cmd(FUNC_SET_STD, 3'd3, STD_SHORT);
    add_cmd(FUNC_SET_STD, 3'd0, STD_NONE);
    add_cmd(FUNC_SET_THRU, 3'd2, 3'd1);
    add_drain();

    // Random: mostly valid commands, the rest over the full field range
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      func = 1'($urandom_range(0, 1));
      if (r < 70) begin
        port = 3'($urandom_range(0, 3));
        if (func == FUNC_SET_STD) value = 3'($urandom_range(0, 3));
        else value = 3'((port + $urandom_range(1, 3)) % NUM_PORTS);
      end else begin
        port  = 3'($urandom_range(0, 7));
        value = 3'($urandom_range(0, 7));
      end
      add_cmd(func, port, value);
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) add_drain();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start || draining) @(posedge clk);
    while (expected_states.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
